// ===== sv/oaht_pkg.sv =====
package oaht_pkg;

  localparam int SLOTS      = 256;  // power of two: start slot is the low hash bits
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = $clog2(SLOTS + 1);
  localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

  // the put load check compares 4*(count+1) against 3*SLOTS
  localparam int LOAD_BITS = COUNT_BITS + 2;
  localparam logic [LOAD_BITS-1:0] LOAD_LIMIT = LOAD_BITS'(3 * SLOTS);

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] put_value;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic                    is_new;
    logic [VALUE_BITS-1:0]   found_value;
    logic [COUNT_BITS-1:0]   occupied_count;
  } out_word_t;

  // single-slot write to the used/tomb flag memory
  typedef struct packed {
    logic                 wr;
    logic [SLOT_BITS-1:0] addr;
    logic                 used;
    logic                 tomb;
  } flag_req_t;

endpackage

// ===== sv/oaht_slot_ram.sv =====
module oaht_slot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/oaht_slot_flags.sv =====
module oaht_slot_flags (
  input  logic                           clk,
  input  oaht_pkg::flag_req_t            req,
  input  logic                           rd_en,
  input  logic [oaht_pkg::SLOT_BITS-1:0] raddr,
  output logic                           rd_used,
  output logic                           rd_tomb
);

  // {used, tomb} per slot; emptied by the sequencer's sweep
  logic [1:0] flags [oaht_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      flags[req.addr] <= {req.used, req.tomb};
    end
  end

  // registered read, lines up with the slot RAM read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_used, rd_tomb} <= flags[raddr];
    end
  end

endmodule

// ===== sv/oaht_probe_seq.sv =====
module oaht_probe_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  oaht_pkg::in_word_t               in_data,
  output logic                             res_valid,
  input  logic                             res_take,
  output oaht_pkg::out_word_t              res_word,
  output logic                             ram_we,
  output logic [oaht_pkg::SLOT_BITS-1:0]   ram_waddr,
  output logic [oaht_pkg::ENTRY_BITS-1:0]  ram_wdata,
  output logic                             ram_re,
  output logic [oaht_pkg::SLOT_BITS-1:0]   ram_raddr,
  input  logic [oaht_pkg::ENTRY_BITS-1:0]  ram_rdata,
  output oaht_pkg::flag_req_t              flag_req,
  input  logic                             rd_used,
  input  logic                             rd_tomb
);

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                              state;
  oaht_pkg::cmd_t                      cmd;
  logic [oaht_pkg::KEY_BITS-1:0]       key;
  logic [oaht_pkg::VALUE_BITS-1:0]     val;
  logic [oaht_pkg::SLOT_BITS-1:0]      idx;
  logic [oaht_pkg::SLOT_BITS-1:0]      n;
  logic [oaht_pkg::SLOT_BITS-1:0]      first_tomb;
  logic                                have_tomb;
  logic                                wipe_reply;
  logic [oaht_pkg::COUNT_BITS-1:0]     count;
  oaht_pkg::status_t                   res_status;
  logic                                res_is_new;
  logic [oaht_pkg::VALUE_BITS-1:0]     res_found;

  logic [oaht_pkg::KEY_BITS-1:0]       rd_key;
  logic [oaht_pkg::VALUE_BITS-1:0]     rd_val;
  logic [oaht_pkg::LOAD_BITS-1:0]      load4;
  logic                                put_full;
  logic                                key_match;
  logic                                is_empty;
  logic                                tomb_here;
  logic                                last;
  logic                                wiping;
  logic                                eval_put;
  logic                                put_hit;
  logic                                put_new_empty;
  logic                                put_new_exh;
  logic                                remove_hit;
  logic [oaht_pkg::SLOT_BITS-1:0]      tgt;

  assign rd_key = ram_rdata[oaht_pkg::ENTRY_BITS-1:oaht_pkg::VALUE_BITS];
  assign rd_val = ram_rdata[oaht_pkg::VALUE_BITS-1:0];

  always_comb begin
    load4     = {count + oaht_pkg::COUNT_BITS'(1), 2'b00};
    put_full  = load4 > oaht_pkg::LOAD_LIMIT;
    key_match = rd_used && (rd_key == key);
    is_empty  = !rd_used && !rd_tomb;
    tomb_here = !rd_used && rd_tomb;
    last      = (n == '1);
    wiping    = (state == S_WIPE);
    eval_put  = (state == S_EVAL) && (cmd == oaht_pkg::CMD_PUT);
    put_hit       = eval_put && key_match;
    put_new_empty = eval_put && is_empty;
    // probe wrapped all the way around: fall back on a tombstone
    put_new_exh   = eval_put && last && !key_match && !is_empty && (have_tomb || tomb_here);
    remove_hit    = (state == S_EVAL) && (cmd == oaht_pkg::CMD_REMOVE) && key_match;
    tgt = (put_hit || !have_tomb) ? idx : first_tomb;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_word  = '{status: res_status, is_new: res_is_new,
                       found_value: res_found, occupied_count: count};

  assign ram_we    = put_hit || put_new_empty || put_new_exh;
  assign ram_waddr = tgt;
  assign ram_wdata = {key, val};
  assign ram_re    = (state == S_READ);
  assign ram_raddr = idx;

  // the sweep writes empty flags, one slot per cycle
  always_comb begin
    flag_req.wr   = wiping || ram_we || remove_hit;
    flag_req.addr = wiping ? n : (remove_hit ? idx : tgt);
    flag_req.used = !wiping && !remove_hit;
    flag_req.tomb = !wiping && remove_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WIPE;
      n          <= '0;
      wipe_reply <= 1'b0;
      count      <= '0;
      have_tomb  <= 1'b0;
    end else begin
      unique case (state)
        S_WIPE: begin
          n <= n + oaht_pkg::SLOT_BITS'(1);
          if (n == '1) begin
            state <= wipe_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= in_data.cmd;
            key        <= in_data.key_id[oaht_pkg::KEY_BITS-1:0];
            val        <= in_data.put_value[oaht_pkg::VALUE_BITS-1:0];
            idx        <= in_data.key_hash[oaht_pkg::SLOT_BITS-1:0];
            n          <= '0;
            have_tomb  <= 1'b0;
            res_status <= oaht_pkg::ST_OK;
            res_is_new <= 1'b0;
            res_found  <= '0;
            unique case (in_data.cmd)
              oaht_pkg::CMD_CLEAR: begin
                count      <= '0;
                wipe_reply <= 1'b1;
                state      <= S_WIPE;
              end
              oaht_pkg::CMD_PUT: begin
                if (put_full) begin
                  res_status <= oaht_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
              oaht_pkg::CMD_GET, oaht_pkg::CMD_REMOVE: begin
                if (count == '0) begin
                  res_status <= oaht_pkg::ST_MISSING;
                  state      <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          priority if (key_match) begin
            if (cmd == oaht_pkg::CMD_GET) begin
              res_found <= rd_val;
            end
            state <= S_DONE;
          end else if (is_empty) begin
            if (cmd == oaht_pkg::CMD_PUT) begin
              res_is_new <= 1'b1;
              if (!have_tomb) begin
                count <= count + oaht_pkg::COUNT_BITS'(1);
              end
            end else begin
              res_status <= oaht_pkg::ST_MISSING;
            end
            state <= S_DONE;
          end else if (last) begin
            if (cmd == oaht_pkg::CMD_PUT) begin
              if (have_tomb || tomb_here) begin
                res_is_new <= 1'b1;
              end else begin
                res_status <= oaht_pkg::ST_FULL;
              end
            end else begin
              res_status <= oaht_pkg::ST_MISSING;
            end
            state <= S_DONE;
          end else begin
            if (tomb_here && !have_tomb) begin
              first_tomb <= idx;
              have_tomb  <= 1'b1;
            end
            idx   <= idx + oaht_pkg::SLOT_BITS'(1);
            n     <= n + oaht_pkg::SLOT_BITS'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    {count, 2'b00} <= oaht_pkg::LOAD_LIMIT)
    else $error("occupancy above load limit");

  a_full_is_put: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == oaht_pkg::ST_FULL) |-> (cmd == oaht_pkg::CMD_PUT))
    else $error("full status on a non-put command");

  a_new_is_put: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_new |-> (cmd == oaht_pkg::CMD_PUT) && (res_status == oaht_pkg::ST_OK))
    else $error("new-key flag outside a successful put");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    in_ready && in_valid && (in_data.cmd == oaht_pkg::CMD_CLEAR) |=> (count == '0) && wiping)
    else $error("clear did not zero the count");

endmodule

// ===== sv/open_address_hash_table_unit.sv =====
// Open-addressing hash table, 256 slots, linear probing with tombstones.
// Input channel in_valid/in_ready/in_data carries one command word: put, get,
// remove or clear, with key id, precomputed hash and value. The start slot is
// the low 8 bits of the hash. Output channel out_valid/out_ready/out_data gives
// one result word per command: status, new-key flag, value read by get, and
// the occupancy count (tombstones included).
// A command is taken only while the sequencer is idle. A rejected put, or a
// get/remove on an empty table, goes straight to the result state; otherwise
// each probed slot takes one read state and one compare state (S_READ, then
// S_EVAL). Clear sweeps the used/tomb flag memory one slot per cycle before
// its result is offered. The sequencer returns to idle at the same edge at
// which its result moves into the output register.
// Reset (rst, synchronous) starts the same flag sweep; in_ready stays low
// until it ends. Key/value RAM is not cleared.
// If out_ready stays low, one result waits in the output register while the
// next command is processed; that command's result then holds in the
// sequencer, which accepts nothing until the output register frees up.
module open_address_hash_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oaht_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oaht_pkg::out_word_t out_data
);

  logic                             res_valid;
  logic                             res_take;
  oaht_pkg::out_word_t              res_word;
  logic                             ram_we;
  logic [oaht_pkg::SLOT_BITS-1:0]   ram_waddr;
  logic [oaht_pkg::ENTRY_BITS-1:0]  ram_wdata;
  logic                             ram_re;
  logic [oaht_pkg::SLOT_BITS-1:0]   ram_raddr;
  logic [oaht_pkg::ENTRY_BITS-1:0]  ram_rdata;
  oaht_pkg::flag_req_t              flag_req;
  logic                             rd_used;
  logic                             rd_tomb;

  oaht_slot_ram #(
    .WIDTH (oaht_pkg::ENTRY_BITS),
    .DEPTH (oaht_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  oaht_slot_flags u_flags (
    .clk     (clk),
    .req     (flag_req),
    .rd_en   (ram_re),
    .raddr   (ram_raddr),
    .rd_used (rd_used),
    .rd_tomb (rd_tomb)
  );

  oaht_probe_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_word  (res_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .flag_req  (flag_req),
    .rd_used   (rd_used),
    .rd_tomb   (rd_tomb)
  );

  // output word register
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_word;
    end
  end

endmodule

// ===== test/oaht_result_checker.sv =====
`timescale 1ns / 100ps

module oaht_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  oaht_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  oaht_pkg::out_word_t out_data,
  output int                  errors,
  output int                  pending,
  output int                  words_checked,
  output int                  full_seen,
  output int                  missing_seen,
  output int                  new_seen
);

  // shadow copy of the table
  logic [oaht_pkg::KEY_BITS-1:0]   tbl_key [oaht_pkg::SLOTS];
  logic [oaht_pkg::VALUE_BITS-1:0] tbl_val [oaht_pkg::SLOTS];
  bit                              tbl_used [oaht_pkg::SLOTS];
  bit                              tbl_tomb [oaht_pkg::SLOTS];
  int                              tbl_count;

  oaht_pkg::out_word_t expected_words[$];
  int                  mismatches;
  int                  checked;
  int                  fulls;
  int                  misses;
  int                  news;

  // Linear probe from the start slot. Returns the slot a put would fill
  // (first tombstone passed wins over the terminating empty slot), or -1.
  function automatic int probe_slots(input logic [oaht_pkg::KEY_BITS-1:0] key,
                                     input logic [31:0] hash, output int hit);
    int idx;
    int first_tomb;
    idx        = int'(hash % 32'(oaht_pkg::SLOTS));
    first_tomb = -1;
    hit        = -1;
    for (int n = 0; n < oaht_pkg::SLOTS; n++) begin
      if (tbl_used[idx]) begin
        if (tbl_key[idx] == key) begin
          hit = idx;
          return idx;
        end
      end else if (tbl_tomb[idx]) begin
        if (first_tomb < 0) first_tomb = idx;
      end else begin
        return (first_tomb >= 0) ? first_tomb : idx;
      end
      idx = (idx + 1) % oaht_pkg::SLOTS;
    end
    return first_tomb;
  endfunction

  function automatic oaht_pkg::out_word_t apply_table_cmd(input oaht_pkg::in_word_t w);
    oaht_pkg::out_word_t r;
    int                  hit;
    int                  slot;
    r        = '0;
    r.status = oaht_pkg::ST_OK;
    unique case (w.cmd)
      oaht_pkg::CMD_PUT: begin
        if (4 * (tbl_count + 1) > 3 * oaht_pkg::SLOTS) begin
          r.status = oaht_pkg::ST_FULL;
        end else begin
          slot = probe_slots(w.key_id[oaht_pkg::KEY_BITS-1:0], w.key_hash, hit);
          if (slot < 0) begin
            r.status = oaht_pkg::ST_FULL;
          end else begin
            if (hit < 0) begin
              r.is_new = 1'b1;
              if (!tbl_tomb[slot]) tbl_count++;
            end
            tbl_used[slot] = 1'b1;
            tbl_tomb[slot] = 1'b0;
            tbl_key[slot]  = w.key_id[oaht_pkg::KEY_BITS-1:0];
            tbl_val[slot]  = w.put_value[oaht_pkg::VALUE_BITS-1:0];
          end
        end
      end
      oaht_pkg::CMD_GET, oaht_pkg::CMD_REMOVE: begin
        if (tbl_count == 0) begin
          r.status = oaht_pkg::ST_MISSING;
        end else begin
          slot = probe_slots(w.key_id[oaht_pkg::KEY_BITS-1:0], w.key_hash, hit);
          if (hit < 0) begin
            r.status = oaht_pkg::ST_MISSING;
          end else if (w.cmd == oaht_pkg::CMD_GET) begin
            r.found_value = tbl_val[hit];
          end else begin
            tbl_used[hit] = 1'b0;
            tbl_tomb[hit] = 1'b1;
          end
        end
      end
      oaht_pkg::CMD_CLEAR: begin
        for (int i = 0; i < oaht_pkg::SLOTS; i++) begin
          tbl_used[i] = 1'b0;
          tbl_tomb[i] = 1'b0;
        end
        tbl_count = 0;
      end
    endcase
    r.occupied_count = oaht_pkg::COUNT_BITS'(tbl_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    oaht_pkg::out_word_t want;
    if (rst) begin
      for (int i = 0; i < oaht_pkg::SLOTS; i++) begin
        tbl_used[i] = 1'b0;
        tbl_tomb[i] = 1'b0;
      end
      tbl_count = 0;
      expected_words.delete();
    end else begin
      // retire the oldest expectation before adding this edge's command
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word: status %0d new %0d value %h count %0d",
                     $time, out_data.status, out_data.is_new, out_data.found_value,
                     out_data.occupied_count);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_data.status !== want.status || out_data.is_new !== want.is_new ||
              out_data.found_value !== want.found_value ||
              out_data.occupied_count !== want.occupied_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected status %0d new %0d value %h count %0d",
                       $time, want.status, want.is_new, want.found_value,
                       want.occupied_count);
              $display("%0t:           got status %0d new %0d value %h count %0d",
                       $time, out_data.status, out_data.is_new, out_data.found_value,
                       out_data.occupied_count);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_table_cmd(in_data);
        expected_words.push_back(want);
        if (want.status == oaht_pkg::ST_FULL) fulls++;
        if (want.status == oaht_pkg::ST_MISSING) misses++;
        if (want.is_new) news++;
      end
    end
    errors        <= mismatches;
    pending       <= expected_words.size();
    words_checked <= checked;
    full_seen     <= fulls;
    missing_seen  <= misses;
    new_seen      <= news;
  end

endmodule

// ===== test/open_address_hash_table_unit_tb.sv =====
`timescale 1ns / 100ps

module open_address_hash_table_unit_tb;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  oaht_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  oaht_pkg::out_word_t out_data;

  int errors;
  int pending;
  int words_checked;
  int full_seen;
  int missing_seen;
  int new_seen;

  int          cmd_sent [4];
  logic [31:0] ep_keys[$];
  logic [31:0] ep_hashes[$];
  bit          send_calm;
  bit          recv_calm;

  open_address_hash_table_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  oaht_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .errors       (errors),
    .pending      (pending),
    .words_checked(words_checked),
    .full_seen    (full_seen),
    .missing_seen (missing_seen),
    .new_seen     (new_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] pick_word32();
    unique case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    unique case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a clock edge; returns at the edge where the word is taken.
  task automatic send_cmd(input oaht_pkg::cmd_t c, input logic [31:0] k,
                          input logic [31:0] h, input logic [63:0] v);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= oaht_pkg::in_word_t'{cmd: c, key_id: k, key_hash: h, put_value: v};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cmd_sent[int'(c)]++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [31:0] ka, kb, kc;
    logic [31:0] k, h;
    int          idx, r, base, spread, nkeys, fills, random_sent;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    fills       = 0;
    random_sent = 0;
    ka = 32'h1234_5678;
    kb = 32'h9ABC_DEF0;
    kc = 32'h0F1E_2D3C;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, collisions, update, tombstone reuse, wrap-around
    send_cmd(oaht_pkg::CMD_GET,    ka, 32'hABCD_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_REMOVE, ka, 32'hABCD_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_PUT,    ka, 32'hABCD_0010, 64'h1111_2222_3333_4444);
    send_cmd(oaht_pkg::CMD_PUT,    kb, 32'h5555_0010, 64'h5555_6666_7777_8888);
    send_cmd(oaht_pkg::CMD_PUT,    ka, 32'hABCD_0010, 64'hA5A5_5A5A_F00D_BEEF);
    send_cmd(oaht_pkg::CMD_GET,    ka, 32'hABCD_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_GET,    kb, 32'h5555_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_GET,    kc, 32'h0F0F_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_REMOVE, ka, 32'hABCD_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_GET,    ka, 32'hABCD_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_GET,    kb, 32'h5555_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_PUT,    kc, 32'h0F0F_0010, 64'hCAFE_0000_0000_CAFE);
    send_cmd(oaht_pkg::CMD_GET,    kc, 32'h0F0F_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(oaht_pkg::CMD_PUT,    32'h0, 32'h0000_00FF, 64'h0);
    send_cmd(oaht_pkg::CMD_GET,    32'h0, 32'h0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(oaht_pkg::CMD_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
    send_cmd(oaht_pkg::CMD_REMOVE, 32'h0, 32'h0000_00FF, 64'h0);
    send_cmd(oaht_pkg::CMD_PUT,    32'h0, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
    send_cmd(oaht_pkg::CMD_REMOVE, 32'hDEAD_BEEF, 32'h0000_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(oaht_pkg::CMD_GET,    kb, 32'h5555_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_REMOVE, kb, 32'h5555_0010, 64'h0);
    send_cmd(oaht_pkg::CMD_PUT,    kb, 32'h5555_0010, 64'h8000_0000_0000_0001);

    while (random_sent < 700) begin
      if (random_sent == 0 || $urandom_range(0, 2) == 0) wait_for_results();
      if ((fills == 0 && random_sent >= 120) || $urandom_range(0, 9) == 0) begin
        // fill toward the load limit, then poke at a full table
        fills++;
        send_cmd(oaht_pkg::CMD_CLEAR, pick_word32(), $urandom, rand64());
        ep_keys.delete();
        ep_hashes.delete();
        base = $urandom_range(0, oaht_pkg::SLOTS - 1);
        for (int i = 0; i < 260; i++) begin
          r = $urandom_range(0, 99);
          if (ep_keys.size() == 0 || r >= 15) begin
            k = pick_word32();
            h = $urandom;
            if ($urandom_range(0, 1) == 0)
              h[oaht_pkg::SLOT_BITS-1:0] = oaht_pkg::SLOT_BITS'(base + $urandom_range(0, 31));
            ep_keys.push_back(k);
            ep_hashes.push_back(h);
            send_cmd(oaht_pkg::CMD_PUT, k, h, rand64());
          end else begin
            idx = $urandom_range(0, ep_keys.size() - 1);
            if (r < 6)
              send_cmd(oaht_pkg::CMD_REMOVE, ep_keys[idx], ep_hashes[idx], rand64());
            else if (r < 10)
              send_cmd(oaht_pkg::CMD_PUT, ep_keys[idx], ep_hashes[idx], rand64());
            else
              send_cmd(oaht_pkg::CMD_GET, ep_keys[idx], ep_hashes[idx], rand64());
          end
        end
        for (int i = 0; i < 4; i++) begin
          idx = $urandom_range(0, ep_keys.size() - 1);
          send_cmd(oaht_pkg::CMD_PUT, ep_keys[idx], ep_hashes[idx], rand64());
          send_cmd(oaht_pkg::CMD_GET, ep_keys[idx], ep_hashes[idx], rand64());
        end
        random_sent += 269;
      end else begin
        // small key set crowded into a few neighboring slots
        nkeys  = $urandom_range(4, 24);
        base   = $urandom_range(0, oaht_pkg::SLOTS - 1);
        spread = $urandom_range(1, 16);
        ep_keys.delete();
        ep_hashes.delete();
        for (int i = 0; i < nkeys; i++) begin
          h = $urandom;
          h[oaht_pkg::SLOT_BITS-1:0] =
              oaht_pkg::SLOT_BITS'(base + $urandom_range(0, spread - 1));
          ep_keys.push_back(pick_word32());
          ep_hashes.push_back(h);
        end
        if ($urandom_range(0, 1) == 0)
          send_cmd(oaht_pkg::CMD_CLEAR, pick_word32(), $urandom, rand64());
        for (int i = 0; i < 60; i++) begin
          idx = $urandom_range(0, nkeys - 1);
          r   = $urandom_range(0, 99);
          if (r < 40)
            send_cmd(oaht_pkg::CMD_PUT, ep_keys[idx], ep_hashes[idx], rand64());
          else if (r < 68)
            send_cmd(oaht_pkg::CMD_GET, ep_keys[idx], ep_hashes[idx], rand64());
          else if (r < 90)
            send_cmd(oaht_pkg::CMD_REMOVE, ep_keys[idx], ep_hashes[idx], rand64());
          else if (r < 93)
            send_cmd(oaht_pkg::CMD_CLEAR, pick_word32(), $urandom, rand64());
          else
            send_cmd(oaht_pkg::cmd_t'($urandom_range(0, 2)), pick_word32(), $urandom,
                     rand64());
        end
        random_sent += 60;
      end
    end

    wait_for_results();
    repeat (520) @(posedge clk);
    $display("Sent %0d put, %0d get, %0d remove, %0d clear; %0d result words checked",
             cmd_sent[oaht_pkg::CMD_PUT], cmd_sent[oaht_pkg::CMD_GET],
             cmd_sent[oaht_pkg::CMD_REMOVE], cmd_sent[oaht_pkg::CMD_CLEAR],
             words_checked);
    $display("Seen %0d new keys, %0d missing-key answers, %0d full rejections",
             new_seen, missing_seen, full_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d bad result words", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/oaht_pkg.sv
sv/oaht_slot_ram.sv
sv/oaht_slot_flags.sv
sv/oaht_probe_seq.sv
sv/open_address_hash_table_unit.sv
test/oaht_result_checker.sv
test/open_address_hash_table_unit_tb.sv
